FILE: design/wlfp_pkg.sv
`default_nettype none
package wlfp_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int POS_W    = 24;
  localparam int STAMP_W  = 32;
  localparam int SIZE_W   = 5;
  localparam int LEAD_W   = 20;
  localparam int FILL_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 20;
  localparam int T_W      = 20;
  localparam int MA_W     = 64;
  localparam int MB_W     = 32;
  localparam int NUM_W    = 96;
  localparam int DEN_W    = 64;

  localparam logic [T_W-1:0]    TIME_SAT = 20'hFFFFF;
  localparam logic [LEAD_W-1:0] LEAD_MAX = 20'd1000000;
  localparam int                DEN_MIN  = 1000000;
  localparam int                SIZE_RESET = 10;
  localparam logic [LEAD_W-1:0] LEAD_RESET = 20'd16000;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_TIME   = 1'd1;

  localparam logic OPC_ADD   = 1'b0;
  localparam logic OPC_CLEAR = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [STAMP_W-1:0]        stamp_us;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pred_x;
    logic signed [POS_W-1:0] pred_y;
    logic                    fit_used;
    logic [FILL_W-1:0]       fill;
  } res_t;

  typedef struct packed {
    logic [STAMP_W-1:0]      stamp_us;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } sample_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_RD, S_LD, S_MGO, S_MWAIT,
    S_DX, S_DXW, S_DY, S_DYW, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_TT, OP_TX, OP_TY, OP_NSTT, OP_STST, OP_NSTX, OP_SXST,
    OP_NSTY, OP_SYST, OP_NE, OP_ND, OP_DSX, OP_NXE, OP_DSY, OP_NYE
  } mop_t;

endpackage
`default_nettype wire

FILE: design/wlfp_ram.sv
`default_nettype none
module wlfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/wlfp_mul.sv
`default_nettype none
module wlfp_mul (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [wlfp_pkg::MA_W-1:0]  a,
  input  wire logic signed [wlfp_pkg::MB_W-1:0]  b,
  output logic                                   done,
  output logic signed [wlfp_pkg::NUM_W-1:0]      p
);
  import wlfp_pkg::*;

  logic             busy;
  logic             neg;
  logic [NUM_W-1:0] acc;
  logic [NUM_W-1:0] ash;
  logic [MB_W-1:0]  bsh;
  logic [MA_W-1:0]  amag;
  logic [MB_W-1:0]  bmag;

  assign amag = a[MA_W-1] ? (~a + 1'b1) : a;
  assign bmag = b[MB_W-1] ? (~b + 1'b1) : b;
  assign p    = neg ? signed'(~acc + 1'b1) : signed'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bsh == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // shift-add, one multiplier bit per cycle, stops at the top set bit
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= NUM_W'(amag);
      bsh <= bmag;
      neg <= a[MA_W-1] ^ b[MB_W-1];
    end else if (busy && bsh != '0) begin
      if (bsh[0]) begin
        acc <= acc + ash;
      end
      ash <= ash << 1;
      bsh <= bsh >> 1;
    end
  end

endmodule
`default_nettype wire

FILE: design/wlfp_div.sv
`default_nettype none
module wlfp_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [wlfp_pkg::NUM_W-1:0] num,
  input  wire logic [wlfp_pkg::DEN_W-1:0]        den,
  output logic                                   done,
  output logic signed [wlfp_pkg::POS_W-1:0]      q
);
  import wlfp_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             big;
  logic [NUM_W-1:0] mag;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem2;
  logic [POS_W:0]   qr;
  logic [NUM_W-1:0] nmag;
  logic             qb;

  assign nmag = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign rem2 = {rem[DEN_W-2:0], mag[NUM_W-1]};
  assign qb   = (rem2 >= dreg);

  always_comb begin
    if (neg) begin
      if (big || qr >= (POS_W+1)'(1 << (POS_W-1))) begin
        q = signed'(POS_W'(1 << (POS_W-1)));
      end else begin
        q = signed'(~qr[POS_W-1:0] + 1'b1);
      end
    end else begin
      if (big || qr > (POS_W+1)'((1 << (POS_W-1)) - 1)) begin
        q = signed'(POS_W'((1 << (POS_W-1)) - 1));
      end else begin
        q = signed'(qr[POS_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle; half divisor added first
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[NUM_W-1];
      mag  <= nmag + NUM_W'(den >> 1);
      dreg <= den;
      rem  <= '0;
      qr   <= '0;
      big  <= 1'b0;
    end else if (busy) begin
      mag <= mag << 1;
      rem <= qb ? rem2 - dreg : rem2;
      big <= big | qr[POS_W];
      qr  <= {qr[POS_W-1:0], qb};
    end
  end

endmodule
`default_nettype wire

FILE: design/windowed_linear_fit_predictor_core.sv
// An empty or one-entry window skips the fit and goes straight to the output state; with
// n >= 2 entries the time is set by the shared shift-add multiplier (three products per
// entry and at most twelve more, fewer when the determinant is too small for a fit)
// and up to two divider passes.
// Throughput: one request at a time; the next is taken the cycle after the result loads.
// Reset: window empty, write slot 0, window_size 10, lead_time_us 16000.
`default_nettype none
module windowed_linear_fit_predictor_core #(
  parameter int WINDOW_MAX = wlfp_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire wlfp_pkg::req_t                    req_data,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output wlfp_pkg::res_t                         res_data,
  input  wire logic                              cfg_we,
  input  wire logic [wlfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wlfp_pkg::CFG_W-1:0]        cfg_data
);
  import wlfp_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

  state_t state, state_next;
  mop_t   op;

  logic [CNT_W-1:0]  window_size;
  logic [LEAD_W-1:0] lead;
  logic [ADDR_W-1:0] write_slot;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [ADDR_W-1:0] ptr;
  logic [CNT_W-1:0]  k;

  logic acc_in, out_load, mul_start, mul_done, div_start, div_done;
  logic at_newest;

  logic [STAMP_W-1:0]      t0;
  logic [T_W-1:0]          cur_t, last_t, t_sat;
  logic [STAMP_W-1:0]      dt;
  logic signed [POS_W-1:0] cur_x, cur_y;
  logic signed [MB_W-1:0]  st, sx, sy, e;
  logic signed [MA_W-1:0]  stt, stx, sty, tmp, d, nx, ny;
  logic [DEN_W-1:0]        den;
  logic signed [NUM_W-1:0] numx, numy, diff, mul_p, div_num;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic [T_W:0]            lead_sum;
  logic signed [POS_W-1:0] div_q, rx, ry;
  logic                    rfit;
  sample_t                 rd_sample;
  logic [CNT_W:0]          old_sum;
  logic [CNT_W-1:0]        v_size;

  assign acc_in     = req_valid && !req_stall;
  assign at_newest  = (k == entry_count - 1'b1);
  assign diff       = NUM_W'(tmp) - mul_p;
  assign dt         = (k == '0) ? '0 : rd_sample.stamp_us - t0;
  assign t_sat      = (dt > STAMP_W'(TIME_SAT)) ? TIME_SAT : dt[T_W-1:0];
  assign lead_sum   = (T_W+1)'(last_t) + (T_W+1)'(lead);
  assign old_sum    = (CNT_W+1)'(write_slot) + (CNT_W+1)'(WINDOW_MAX)
                    - (CNT_W+1)'(entry_count);
  assign v_size     = (int'(cfg_data[SIZE_W-1:0]) < 2) ? CNT_W'(2) :
                      (int'(cfg_data[SIZE_W-1:0]) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) :
                      CNT_W'(cfg_data[SIZE_W-1:0]);

  wlfp_ram #(.WIDTH($bits(sample_t)), .DEPTH(WINDOW_MAX)) u_ram (
    .clk   (clk),
    .we    (acc_in && req_data.opcode == OPC_ADD),
    .waddr (write_slot),
    .wdata ({req_data.stamp_us, req_data.pos_y, req_data.pos_x}),
    .raddr (ptr),
    .rdata (rd_sample)
  );

  always_comb begin
    case (op)
      OP_TT:   begin mul_a = MA_W'(cur_t);    mul_b = MB_W'(cur_t);       end
      OP_TX:   begin mul_a = MA_W'(cur_x);    mul_b = MB_W'(cur_t);       end
      OP_TY:   begin mul_a = MA_W'(cur_y);    mul_b = MB_W'(cur_t);       end
      OP_NSTT: begin mul_a = stt;             mul_b = MB_W'(entry_count); end
      OP_STST: begin mul_a = MA_W'(st);       mul_b = st;                 end
      OP_NSTX: begin mul_a = stx;             mul_b = MB_W'(entry_count); end
      OP_SXST: begin mul_a = MA_W'(sx);       mul_b = st;                 end
      OP_NSTY: begin mul_a = sty;             mul_b = MB_W'(entry_count); end
      OP_SYST: begin mul_a = MA_W'(sy);       mul_b = st;                 end
      OP_NE:   begin mul_a = MA_W'(lead_sum); mul_b = MB_W'(entry_count); end
      OP_ND:   begin mul_a = d;               mul_b = MB_W'(entry_count); end
      OP_DSX:  begin mul_a = d;               mul_b = sx;                 end
      OP_NXE:  begin mul_a = nx;              mul_b = e;                  end
      OP_DSY:  begin mul_a = d;               mul_b = sy;                 end
      OP_NYE:  begin mul_a = ny;              mul_b = e;                  end
      default: begin mul_a = '0;              mul_b = '0;                 end
    endcase
  end

  assign div_num = (state == S_DY) ? numy : numx;

  wlfp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  wlfp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    entry_count_next = entry_count;
    if (acc_in) begin
      if (req_data.opcode == OPC_CLEAR) begin
        entry_count_next = '0;
      end else if (entry_count < window_size) begin
        entry_count_next = entry_count + 1'b1;
      end
    end else if (cfg_we && cfg_index == REG_WINDOW_SIZE && entry_count > v_size) begin
      entry_count_next = v_size;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_in) begin
          state_next = (entry_count_next >= CNT_W'(2)) ? S_INIT : S_OUT;
        end
      end
      S_INIT: state_next = S_RD;
      S_RD:   state_next = S_LD;
      S_LD:   state_next = S_MGO;
      S_MGO:  state_next = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          case (op)
            OP_TY:   state_next = at_newest ? S_MGO : S_RD;
            OP_STST: state_next = (diff > NUM_W'(DEN_MIN)) ? S_MGO : S_OUT;
            OP_NYE:  state_next = S_DX;
            default: state_next = S_MGO;
          endcase
        end
      end
      S_DX:  state_next = S_DXW;
      S_DXW: state_next = div_done ? S_DY : S_DXW;
      S_DY:  state_next = S_DYW;
      S_DYW: state_next = div_done ? S_OUT : S_DYW;
      S_OUT: state_next = out_load ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != S_IDLE);
    mul_start = (state == S_MGO);
    div_start = (state == S_DX) || (state == S_DY);
    out_load  = (state == S_OUT) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_TT;
      window_size <= CNT_W'(SIZE_RESET);
      lead        <= LEAD_RESET;
      write_slot  <= '0;
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_SIZE: window_size <= v_size;
          REG_LEAD_TIME:   lead <= (cfg_data[LEAD_W-1:0] > LEAD_MAX) ? LEAD_MAX
                                                                     : cfg_data[LEAD_W-1:0];
          default: ;
        endcase
      end
      if (acc_in && req_data.opcode == OPC_ADD) begin
        write_slot <= (write_slot == ADDR_W'(WINDOW_MAX - 1)) ? '0 : write_slot + 1'b1;
      end
      if (state == S_LD) begin
        op <= OP_TT;
      end else if (state == S_MWAIT && mul_done) begin
        case (op)
          OP_TT:   op <= OP_TX;
          OP_TX:   op <= OP_TY;
          OP_TY:   op <= at_newest ? OP_NSTT : OP_TT;
          OP_NSTT: op <= OP_STST;
          OP_STST: op <= OP_NSTX;
          OP_NSTX: op <= OP_SXST;
          OP_SXST: op <= OP_NSTY;
          OP_NSTY: op <= OP_SYST;
          OP_SYST: op <= OP_NE;
          OP_NE:   op <= OP_ND;
          OP_ND:   op <= OP_DSX;
          OP_DSX:  op <= OP_NXE;
          OP_NXE:  op <= OP_DSY;
          OP_DSY:  op <= OP_NYE;
          default: op <= OP_TT;
        endcase
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      rx   <= (req_data.opcode == OPC_CLEAR) ? '0 : req_data.pos_x;
      ry   <= (req_data.opcode == OPC_CLEAR) ? '0 : req_data.pos_y;
      rfit <= 1'b0;
      st   <= '0;
      sx   <= '0;
      sy   <= '0;
      stt  <= '0;
      stx  <= '0;
      sty  <= '0;
    end
    case (state)
      S_INIT: begin
        ptr <= (old_sum >= (CNT_W+1)'(WINDOW_MAX)) ?
               ADDR_W'(old_sum - (CNT_W+1)'(WINDOW_MAX)) : ADDR_W'(old_sum);
        k   <= '0;
      end
      S_LD: begin
        if (k == '0) begin
          t0 <= rd_sample.stamp_us;
        end
        cur_t  <= t_sat;
        last_t <= t_sat;
        cur_x  <= rd_sample.pos_x;
        cur_y  <= rd_sample.pos_y;
        st     <= st + MB_W'(t_sat);
        sx     <= sx + MB_W'(rd_sample.pos_x);
        sy     <= sy + MB_W'(rd_sample.pos_y);
      end
      S_MWAIT: begin
        if (mul_done) begin
          case (op)
            OP_TT:   stt <= stt + mul_p[MA_W-1:0];
            OP_TX:   stx <= stx + mul_p[MA_W-1:0];
            OP_TY: begin
              sty <= sty + mul_p[MA_W-1:0];
              if (!at_newest) begin
                k   <= k + 1'b1;
                ptr <= (ptr == ADDR_W'(WINDOW_MAX - 1)) ? '0 : ptr + 1'b1;
              end
            end
            OP_NSTT: tmp  <= mul_p[MA_W-1:0];
            OP_STST: d    <= diff[MA_W-1:0];
            OP_NSTX: tmp  <= mul_p[MA_W-1:0];
            OP_SXST: nx   <= diff[MA_W-1:0];
            OP_NSTY: tmp  <= mul_p[MA_W-1:0];
            OP_SYST: ny   <= diff[MA_W-1:0];
            OP_NE:   e    <= mul_p[MB_W-1:0] - st;
            OP_ND:   den  <= mul_p[DEN_W-1:0];
            OP_DSX:  numx <= mul_p;
            OP_NXE:  numx <= numx + mul_p;
            OP_DSY:  numy <= mul_p;
            OP_NYE:  numy <= numy + mul_p;
            default: ;
          endcase
        end
      end
      S_DXW: begin
        if (div_done) begin
          rx <= div_q;
        end
      end
      S_DYW: begin
        if (div_done) begin
          ry   <= div_q;
          rfit <= 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      res_data.pred_x   <= rx;
      res_data.pred_y   <= ry;
      res_data.fit_used <= rfit;
      res_data.fill     <= FILL_W'(entry_count);
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_windowed_linear_fit_predictor_core.sv
`default_nettype none
module tb_windowed_linear_fit_predictor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wlfp_pkg::*;

  localparam int REQ_W = $bits(req_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_SIZE;
  logic [CFG_W-1:0] cfg_data = '0;

  windowed_linear_fit_predictor_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  longint trail_x [16];
  longint trail_y [16];
  int unsigned trail_t [16];
  int unsigned head_slot;
  int unsigned depth_cnt;
  int unsigned win_len;
  int unsigned lead_us;

  res_t fit_queue [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // track generator state
  longint trk_x, trk_y, vel_x, vel_y;
  int unsigned trk_t;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic signed [23:0] round_sat(input logic signed [127:0] num,
                                                   input logic [127:0] den);
    logic neg;
    logic [127:0] mag;
    logic [127:0] q;
    neg = num[127];
    mag = neg ? -num : num;
    mag = mag + (den >> 1);
    q = mag / den;
    if (neg) begin
      if (q >= 128'd8388608) return -24'sd8388608;
      return -$signed(q[23:0]);
    end
    if (q > 128'd8388607) return 24'sd8388607;
    return q[23:0];
  endfunction

  function automatic res_t predict_fit(input req_t rq);
    res_t r;
    int unsigned n, newest, oldest, idx, dt;
    longint t, st, stt, sx, sy, stx, sty, last_t, d, e, nx, ny;
    r = '0;
    if (rq.opcode == OPC_CLEAR) begin
      depth_cnt = 0;
    end else begin
      trail_x[head_slot] = longint'(rq.pos_x);
      trail_y[head_slot] = longint'(rq.pos_y);
      trail_t[head_slot] = rq.stamp_us;
      head_slot = (head_slot + 1) % 16;
      if (depth_cnt < win_len) depth_cnt++;
    end
    n = depth_cnt;
    newest = (head_slot + 15) % 16;
    if (n >= 1) begin
      r.pred_x = trail_x[newest][23:0];
      r.pred_y = trail_y[newest][23:0];
    end
    if (n >= 2) begin
      oldest = (head_slot + 16 - n) % 16;
      st = 0; stt = 0; sx = 0; sy = 0; stx = 0; sty = 0; last_t = 0;
      for (int k = 0; k < n; k++) begin
        idx = (oldest + k) % 16;
        dt = trail_t[idx] - trail_t[oldest];
        t = (dt > 1048575) ? 1048575 : dt;
        st += t;
        stt += t * t;
        sx += trail_x[idx];
        sy += trail_y[idx];
        stx += t * trail_x[idx];
        sty += t * trail_y[idx];
        last_t = t;
      end
      d = n * stt - st * st;
      if (d > 1000000) begin
        e = n * (last_t + lead_us) - st;
        nx = n * stx - st * sx;
        ny = n * sty - st * sy;
        r.pred_x = round_sat(128'(sx) * 128'(d) + 128'(nx) * 128'(e),
                             128'(n) * 128'(d));
        r.pred_y = round_sat(128'(sy) * 128'(d) + 128'(ny) * 128'(e),
                             128'(n) * 128'(d));
        r.fit_used = 1'b1;
      end
    end
    r.fill = n[4:0];
    return r;
  endfunction

  always @(negedge clk) res_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (fit_queue.size() == 0) begin
        report("result with nothing pending");
      end else begin
        want = fit_queue[0];
        fit_queue.delete(0);
        if (res_data.pred_x !== want.pred_x)
          report($sformatf("pred_x %0d want %0d", res_data.pred_x, want.pred_x));
        if (res_data.pred_y !== want.pred_y)
          report($sformatf("pred_y %0d want %0d", res_data.pred_y, want.pred_y));
        if (res_data.fit_used !== want.fit_used)
          report($sformatf("fit_used %0b want %0b", res_data.fit_used, want.fit_used));
        if (res_data.fill !== want.fill)
          report($sformatf("fill %0d want %0d", res_data.fill, want.fill));
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input req_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= rq;
    do @(posedge clk); while (req_stall);
    fit_queue.insert(fit_queue.size(), predict_fit(rq));
    @(negedge clk);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    while (fit_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int unsigned v;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_SIZE) begin
      v = 32'(val[4:0]);
      if (v < 2) v = 2;
      if (v > 16) v = 16;
      win_len = v;
      if (depth_cnt > win_len) depth_cnt = win_len;
    end else begin
      v = 32'(val);
      if (v > 1000000) v = 1000000;
      lead_us = v;
    end
  endtask

  function automatic req_t make_add(input longint x, input longint y, input int unsigned ts);
    req_t rq;
    rq.opcode = OPC_ADD;
    rq.pos_x = x[23:0];
    rq.pos_y = y[23:0];
    rq.stamp_us = ts;
    return rq;
  endfunction

  function automatic req_t make_clear();
    req_t rq;
    rq = REQ_W'({$urandom, $urandom, $urandom});
    rq.opcode = OPC_CLEAR;
    return rq;
  endfunction

  task automatic test_directed;
    send_request(make_clear());
    send_request(make_add(-8388608, 8388607, 32'hFFFF_FF00));
    send_request(make_add(8388607, -8388608, 32'hFFFF_FF00));
    send_request(make_add(8388607, -8388608, 32'h0000_0300));
    send_request(make_add(8388607, -8388608, 32'h0000_0800));
    send_request(make_add(0, 0, 32'h0010_0000));
    send_request(make_add(-1, 1, 32'h8000_0000));
    send_request(make_clear());
    send_request(make_add(100, 200, 5000));
    send_request(make_add(300, 400, 5000));
    for (int k = 1; k <= 10; k++) send_request(make_add(256 * k, -512 * k, 5000 + 1000 * k));
    write_reg(REG_WINDOW_SIZE, 20'd4);
    send_request(make_add(3000, -6000, 16000));
    write_reg(REG_WINDOW_SIZE, 20'd16);
    send_request(make_add(3256, -6512, 17000));
    send_request(make_clear());
  endtask

  task automatic test_tracks(input int count);
    req_t rq;
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        rq = make_clear();
      end else if (sel < 13) begin
        rq = REQ_W'({$urandom, $urandom, $urandom});
        rq.opcode = OPC_ADD;
      end else begin
        if (sel < 18) begin
          trk_x = $signed(24'($urandom));
          trk_y = $signed(24'($urandom));
          vel_x = longint'($urandom_range(8000)) - 4000;
          vel_y = longint'($urandom_range(8000)) - 4000;
        end
        trk_x += vel_x + longint'($urandom_range(64)) - 32;
        trk_y += vel_y + longint'($urandom_range(64)) - 32;
        case ($urandom_range(19))
          0: trk_t += 0;
          1: trk_t += $urandom;
          2: trk_t += $urandom_range(2000000, 1048000);
          default: trk_t += $urandom_range(3000, 200);
        endcase
        rq = make_add(trk_x, trk_y, trk_t);
      end
      send_request(rq);
    end
  endtask

  task automatic test_phase(input int sidle, input int rstall);
    send_idle_pct = sidle;
    stall_pct = rstall;
    write_reg(REG_WINDOW_SIZE, 20'd2);
    write_reg(REG_LEAD_TIME, 20'd0);
    test_tracks(100);
    write_reg(REG_WINDOW_SIZE, 20'd31);
    write_reg(REG_LEAD_TIME, 20'd1000000);
    test_tracks(80);
    write_reg(REG_WINDOW_SIZE, 20'd0);
    write_reg(REG_LEAD_TIME, 20'hFFFFF);
    test_tracks(100);
    write_reg(REG_WINDOW_SIZE, 20'($urandom_range(17, 2)));
    write_reg(REG_LEAD_TIME, 20'($urandom_range(1000000)));
    test_tracks(130);
  endtask

  initial begin
    head_slot = 0;
    depth_cnt = 0;
    win_len = 10;
    lead_us = 16000;
    trk_x = 0; trk_y = 0; vel_x = 100; vel_y = -100; trk_t = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_phase(19, 46);
    test_phase(46, 19);
    test_phase(0, 0);
    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("windowed_linear_fit_predictor_core regression: pass");
    end else begin
      $display("windowed_linear_fit_predictor_core regression: fail");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("windowed_linear_fit_predictor_core regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

FILE: windowed_linear_fit_predictor_core.f
design/wlfp_pkg.sv
design/wlfp_ram.sv
design/wlfp_mul.sv
design/wlfp_div.sv
design/windowed_linear_fit_predictor_core.sv
tb/tb_windowed_linear_fit_predictor_core.sv
